/* hw/rtl/modexp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths, register indexes and payload types.
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int unsigned ModBits  = 31;
  localparam int unsigned CntBits  = $clog2(ModBits + 1);
  localparam int unsigned AddrBits = 3;

  localparam logic [AddrBits-1:0] RegModulus  = 3'd0;
  localparam logic [AddrBits-1:0] RegExponent = 3'd4;

  typedef logic [ModBits-1:0] word_t;

  typedef struct packed {
    word_t base;
    logic  last_item;
  } in_item_t;

  typedef struct packed {
    word_t power_result;
    logic  last_result;
  } out_item_t;

  // Control between sequencer and the modular multiplier or base reducer.
  typedef struct packed {
    logic start;
  } mul_req_t;

  typedef struct packed {
    logic done;
  } mul_rsp_t;

endpackage
`default_nettype wire

/* hw/rtl/modexp_mulmod.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular multiplier
// Bit-serial interleaved multiply: one multiplier bit per cycle, MSB first.
// Operands must be below the modulus; modulus must be nonzero.
// ----------------------------------------------------------------------------
module modexp_mulmod (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire modexp_pkg::mul_req_t req_i,
  input  wire modexp_pkg::word_t   a_i,
  input  wire modexp_pkg::word_t   b_i,
  input  wire modexp_pkg::word_t   m_i,
  output modexp_pkg::mul_rsp_t     rsp_o,
  output modexp_pkg::word_t        p_o
);

  logic                           busy_q, busy_d;
  logic [modexp_pkg::CntBits-1:0] cnt_q, cnt_d;
  modexp_pkg::word_t              acc_q, acc_d, a_q, a_d, b_q, b_d;
  logic                           done_q, done_d;

  logic [modexp_pkg::ModBits:0] dbl, dbl_r, sum;
  modexp_pkg::word_t            dbl_red;

  always_comb begin
    dbl     = {acc_q, 1'b0};
    dbl_r   = dbl - {1'b0, m_i};
    dbl_red = (dbl >= {1'b0, m_i}) ? dbl_r[modexp_pkg::ModBits-1:0]
                                   : dbl[modexp_pkg::ModBits-1:0];
    sum     = {1'b0, dbl_red} + {1'b0, a_q};
    if (b_q[modexp_pkg::ModBits-1]) begin
      if (sum >= {1'b0, m_i}) begin
        sum = sum - {1'b0, m_i};
      end
    end else begin
      sum = {1'b0, dbl_red};
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      acc_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
    end else if (busy_q) begin
      acc_d = sum[modexp_pkg::ModBits-1:0];
      b_d   = {b_q[modexp_pkg::ModBits-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == modexp_pkg::CntBits'(modexp_pkg::ModBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign rsp_o.done = done_q;
  assign p_o        = acc_q;

endmodule
`default_nettype wire

/* hw/rtl/modexp_reduce.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Base reducer
// Restoring remainder of base by modulus, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module modexp_reduce (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire modexp_pkg::mul_req_t req_i,
  input  wire modexp_pkg::word_t   x_i,
  input  wire modexp_pkg::word_t   m_i,
  output modexp_pkg::mul_rsp_t     rsp_o,
  output modexp_pkg::word_t        r_o
);

  logic                           busy_q, busy_d, done_q, done_d;
  logic [modexp_pkg::CntBits-1:0] cnt_q, cnt_d;
  modexp_pkg::word_t              rem_q, rem_d, x_q, x_d;
  logic [modexp_pkg::ModBits:0]   sh;

  always_comb begin
    sh     = {rem_q, x_q[modexp_pkg::ModBits-1]};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    x_d    = x_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      x_d    = x_i;
    end else if (busy_q) begin
      rem_d = (sh >= {1'b0, m_i}) ? modexp_pkg::ModBits'(sh - {1'b0, m_i})
                                  : sh[modexp_pkg::ModBits-1:0];
      x_d   = {x_q[modexp_pkg::ModBits-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == modexp_pkg::CntBits'(modexp_pkg::ModBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    x_q   <= x_d;
  end

  assign rsp_o.done = done_q;
  assign r_o        = rem_q;

endmodule
`default_nettype wire

/* hw/rtl/modular_exponentiation.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular exponentiation
// base ** exponent mod modulus, right-to-left square and multiply.
// ----------------------------------------------------------------------------
// Sequence: base reduction, then per exponent bit an issue step, a modular
//   multiply on a set bit and a square; for modulus zero the result goes to the
//   output without reduction or multiplies. A stalled output delays the result.
// Flow: one transaction at a time; the next input is taken the cycle after the
//   result register is loaded.
// Reset: modulus 2, exponent 1, datapath idle, no result pending.
module modular_exponentiation (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire modexp_pkg::in_item_t    in_data_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output modexp_pkg::out_item_t        out_data_o,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [modexp_pkg::AddrBits-1:0] paddr,
  input  wire [31:0]                   pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  // Sequencer states.
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRed  = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StSq   = 3'd3;
  localparam logic [2:0] StNext = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0]                     state_q, state_d;
  modexp_pkg::word_t              mod_q, exp_q;
  modexp_pkg::word_t              res_q, res_d, sq_q, sq_d, e_q, e_d;
  logic [modexp_pkg::CntBits-1:0] bit_q, bit_d;
  logic                           last_q, last_d;
  logic                           ovalid_q, ovalid_d;
  modexp_pkg::out_item_t          odata_q, odata_d;

  modexp_pkg::mul_req_t red_req, mul_req;
  modexp_pkg::mul_rsp_t red_rsp, mul_rsp;
  modexp_pkg::word_t    red_r, mul_a, mul_b, mul_p;
  logic                 in_acc, mod_zero, mod_one;

  // Configuration writes land in the access phase.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= modexp_pkg::ModBits'(2);
      exp_q <= modexp_pkg::ModBits'(1);
    end else if (psel && penable && pwrite) begin
      case (paddr)
        modexp_pkg::RegModulus:  mod_q <= pwdata[modexp_pkg::ModBits-1:0];
        modexp_pkg::RegExponent: exp_q <= pwdata[modexp_pkg::ModBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      modexp_pkg::RegModulus:  prdata = {1'b0, mod_q};
      modexp_pkg::RegExponent: prdata = {1'b0, exp_q};
      default:                 prdata = '0;
    endcase
  end

  assign mod_zero = (mod_q == '0);
  assign mod_one  = (mod_q == modexp_pkg::ModBits'(1));

  // Accept only while idle; a new result waits in StOut until the result register frees.
  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign red_req.start = in_acc && !mod_zero;
  assign mul_a = res_q;
  assign mul_b = sq_q;

  modexp_reduce u_reduce (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (red_req),
    .x_i   (in_data_i.base),
    .m_i   (mod_q),
    .rsp_o (red_rsp),
    .r_o   (red_r)
  );

  modexp_mulmod u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mul_req),
    .a_i   ((state_q == StSq || state_d == StSq) ? sq_q : mul_a),
    .b_i   (mul_b),
    .m_i   (mod_q),
    .rsp_o (mul_rsp),
    .p_o   (mul_p)
  );

  always_comb begin
    state_d       = state_q;
    res_d         = res_q;
    sq_d          = sq_q;
    e_d           = e_q;
    bit_d         = bit_q;
    last_d        = last_q;
    ovalid_d      = ovalid_q;
    odata_d       = odata_q;
    mul_req.start = 1'b0;
    // Drop the result once taken.
    if (ovalid_q && !out_stall_i) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          last_d = in_data_i.last_item;
          e_d    = exp_q;
          bit_d  = '0;
          res_d  = mod_one ? '0 : modexp_pkg::ModBits'(1);
          if (mod_zero) begin
            res_d   = '0;
            state_d = StOut;
          end else begin
            state_d = StRed;
          end
        end
      end
      StRed: begin
        if (red_rsp.done) begin
          sq_d    = red_r;
          state_d = StNext;
        end
      end
      StNext: begin
        // After the last exponent bit go to output; otherwise multiply on a set bit, else square.
        if (bit_q == modexp_pkg::CntBits'(modexp_pkg::ModBits)) begin
          state_d = StOut;
        end else if (e_q[0]) begin
          mul_req.start = 1'b1;
          state_d       = StMul;
        end else begin
          mul_req.start = 1'b1;
          state_d       = StSq;
        end
      end
      StMul: begin
        if (mul_rsp.done) begin
          res_d         = mul_p;
          mul_req.start = 1'b1;
          state_d       = StSq;
        end
      end
      StSq: begin
        if (mul_rsp.done) begin
          sq_d    = mul_p;
          e_d     = e_q >> 1;
          bit_d   = bit_q + 1'b1;
          state_d = StNext;
        end
      end
      StOut: begin
        if (!ovalid_d) begin
          ovalid_d                  = 1'b1;
          odata_d.power_result      = res_q;
          odata_d.last_result       = last_q;
          state_d                   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
      bit_q    <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      bit_q    <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    sq_q    <= sq_d;
    e_q     <= e_d;
    last_q  <= last_d;
    odata_q <= odata_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

endmodule
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives base words through the exponentiation unit under a series of
// modulus/exponent settings and checks each result against a local
// square-and-multiply predictor.
// ----------------------------------------------------------------------------

// Track expected results in arrival order and compare each output against the
// oldest one.
class powmod_scoreboard;
  modexp_pkg::out_item_t pending_q[$];
  int unsigned           mismatches;
  logic [30:0]           modulus;
  logic [30:0]           exponent;

  function new();
    mismatches = 0;
    modulus    = 31'd2;
    exponent   = 31'd1;
  endfunction

  // Return (a * b) mod m with a, b < m.
  function automatic logic [30:0] mulmod(logic [30:0] a, logic [30:0] b,
                                         logic [30:0] m);
    logic [63:0] prod;
    prod = 64'(a) * 64'(b);
    return 31'(prod % 64'(m));
  endfunction

  function automatic logic [30:0] powmod(logic [30:0] b);
    logic [30:0] acc;
    logic [30:0] sq;
    if (modulus == 0) return '0;
    acc = 31'(1 % modulus);
    sq  = 31'(b % modulus);
    for (int k = 0; k < 31; k++) begin
      if (exponent[k]) acc = mulmod(acc, sq, modulus);
      sq = mulmod(sq, sq, modulus);
    end
    return acc;
  endfunction

  function void note_input(modexp_pkg::in_item_t it);
    modexp_pkg::out_item_t e;
    e.power_result = powmod(it.base);
    e.last_result  = it.last_item;
    pending_q.push_back(e);
  endfunction

  function void check_result(modexp_pkg::out_item_t got);
    modexp_pkg::out_item_t e;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
      return;
    end
    e = pending_q.pop_front();
    if (got.power_result !== e.power_result || got.last_result !== e.last_result) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: result exp %0d/%0b got %0d/%0b (n=%0d e=%0d)",
                 e.power_result, e.last_result, got.power_result,
                 got.last_result, modulus, exponent);
    end
  endfunction
endclass

module tb_top;
  import modexp_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [AddrBits-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  powmod_scoreboard powmod_sb;
  bit          feeding_done = 1'b0;
  int unsigned rx_wait = 0;

  modular_exponentiation i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // Write one register: setup cycle, then access cycle; update the predictor.
  task automatic write_reg(logic [AddrBits-1:0] addr, logic [30:0] value);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= {1'b0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == RegModulus) powmod_sb.modulus = value;
    else powmod_sb.exponent = value;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Offer one word after a random gap; hold it until accepted. Valid stays
  // high after acceptance so that a zero gap needs no second drive.
  task automatic send_word(logic [30:0] b, logic last);
    int gap;
    gap = $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i  <= '{base: b, last_item: last};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    powmod_sb.note_input('{base: b, last_item: last});
    @(negedge clk_i);
  endtask

  // Drain the block before touching the registers again.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (powmod_sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // Pick a random word, biased toward the edges and small values.
  function automatic logic [30:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 31'($urandom);
      1: return 31'($urandom_range(0, 255));
      2: return 31'h7fffffff - 31'($urandom_range(0, 3));
      default: return 31'($urandom);
    endcase
  endfunction

  // Receiver: hold each result for a drawn number of cycles, then take it.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && rx_wait != 0) begin
        out_stall_i <= 1'b1;
        rx_wait = rx_wait - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      powmod_sb.check_result(out_data_o);
      rx_wait = $urandom_range(0, 12);
    end
  end

  // Main stimulus.
  initial begin
    logic [30:0] mods [6];
    logic [30:0] exps [6];
    powmod_sb = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Reset settings: n = 2, e = 1; edges of base and last flag.
    send_word(31'd0, 1'b0);
    send_word(31'd1, 1'b1);
    send_word(31'h7fffffff, 1'b0);
    send_word(31'h2aaaaaaa, 1'b1);
    send_word(31'h55555555, 1'b0);
    wait_idle();

    // Directed settings: largest modulus/exponent, exponent zero, modulus one,
    // modulus zero, base not below modulus.
    mods = '{31'h7fffffff, 31'd97, 31'd1, 31'd0, 31'd3233, 31'h7fffffff};
    exps = '{31'h7fffffff, 31'd0, 31'd5, 31'd7, 31'd17, 31'd0};
    for (int s = 0; s < 6; s++) begin
      write_reg(RegModulus, mods[s]);
      write_reg(RegExponent, exps[s]);
      send_word(31'd0, 1'b0);
      send_word(31'h7fffffff, 1'b1);
      send_word(mods[s], 1'b0);
      wait_idle();
    end

    // Random phases: new settings every 20 words.
    for (int p = 0; p < 28; p++) begin
      case (p % 4)
        0: write_reg(RegModulus, 31'($urandom_range(2, 65535)));
        1: write_reg(RegModulus, 31'($urandom) | 31'h40000000);
        2: write_reg(RegModulus, rand_word());
        default: write_reg(RegModulus, 31'($urandom_range(2, 4000)));
      endcase
      write_reg(RegExponent, (p % 7 == 3) ? 31'd0 : rand_word());
      for (int k = 0; k < 20; k++) send_word(rand_word(), 1'($urandom_range(0, 1)));
      wait_idle();
    end
    feeding_done = 1'b1;
  end

  // Finish once stimulus is spent and all results are in.
  initial begin
    wait (feeding_done);
    if (powmod_sb.mismatches == 0 && powmod_sb.pending_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Timeout: 583 words at their worst-case transaction time plus stalls, several times over.
  initial begin
    #80ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
